### sv/dfu_pkg.sv
`timescale 1ns / 1ps

package dfu_pkg;

  localparam int DFU_BLOCK_BYTES = 1024;

  typedef enum logic [2:0] {
    OP_DNLOAD      = 3'd0,
    OP_GETSTATUS   = 3'd1,
    OP_GETSTATE    = 3'd2,
    OP_CLRSTATUS   = 3'd3,
    OP_ABORT       = 3'd4,
    OP_STATUS_DONE = 3'd5,
    OP_OTHER       = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd2,
    ST_DNSYNC   = 4'd3,
    ST_DNBUSY   = 4'd4,
    ST_DNIDLE   = 4'd5,
    ST_MFSYNC   = 4'd6,
    ST_MANIFEST = 4'd7,
    ST_ERROR    = 4'd10
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_PROGRAM = 2'd1,
    CMD_ERASE   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_TARGET_SEL = 2'd0,
    CFG_APP_BASE   = 2'd1,
    CFG_MAP_BASE   = 2'd2,
    CFG_MARKER     = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] RTYPE_CLASS   = 2'b01;
  localparam logic [2:0] LEN_GETSTATUS = 3'd6;
  localparam logic [2:0] LEN_GETSTATE  = 3'd1;
  localparam logic [2:0] LEN_NONE      = 3'd0;
  localparam logic [6:0] POLL_MS       = 7'd100;
  localparam logic       STATUS_OK     = 1'b0;
  localparam logic       STATUS_NOTDONE = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  request_type;
    logic [15:0] block_number;
    logic [15:0] transfer_length;
  } req_t;

  typedef struct packed {
    logic        handled;
    logic [2:0]  reply_length;
    logic        status_code;
    logic [6:0]  poll_timeout;
    logic [3:0]  state_code;
    logic [1:0]  flash_command;
    logic [31:0] flash_address;
  } rsp_t;

endpackage

### sv/dfu_request_state_machine_top.sv
`timescale 1ns / 1ps

// DFU 1.1 download-session controller, device side.
// Input channel (in_*): one class request or one status-stage completion
// event per request, valid/ready. Output channel (out_*): exactly one reply
// per request, valid/ready, in request order.
// Configuration (cfg_*): write enable, register index, 32-bit data; write
// only while no request is in flight.
// Path: a request accepted on in_* is held in the input register; the state
// update is then registered into the reply register, which drives out_*.
// Throughput: one request per cycle while the reply register is empty or
// being accepted; the state update is a single pass through the decode logic
// plus one 16x32 multiply-add for the flash address. A full reply register
// that is not accepted stalls the input register, which deasserts in_ready
// once it also holds a request; nothing is lost or repeated.
// Reset: synchronous, active low. DFU state returns to idle, status ok,
// pending block/length zero, completion disarmed, all configuration registers zero.
// An armed completion in the manifest state emits the erase-and-reset command and
// returns the DFU state to its reset values; registers are kept.
module dfu_request_state_machine_top #(
  parameter int BLOCK_BYTES = dfu_pkg::DFU_BLOCK_BYTES,
  parameter int FLEN_W      = $clog2(BLOCK_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_operation,
  input  logic [7:0]        in_request_type,
  input  logic [15:0]       in_block_number,
  input  logic [15:0]       in_transfer_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_handled,
  output logic [2:0]        out_reply_length,
  output logic              out_status_code,
  output logic [6:0]        out_poll_timeout,
  output logic [3:0]        out_state_code,
  output logic [1:0]        out_flash_command,
  output logic [31:0]       out_flash_address,
  output logic [FLEN_W-1:0] out_flash_length
);
  import dfu_pkg::*;

  req_t              in_req;
  req_t              req;
  logic              req_valid;
  logic              advance;
  rsp_t              rsp;
  rsp_t              out_rsp;
  logic [FLEN_W-1:0] rsp_flen;

  assign in_req.operation       = in_operation;
  assign in_req.request_type    = in_request_type;
  assign in_req.block_number    = in_block_number;
  assign in_req.transfer_length = in_transfer_length;

  dfu_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  dfu_ctrl #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .FLEN_W      (FLEN_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (req_valid && advance),
    .req       (req),
    .rsp       (rsp),
    .rsp_flen  (rsp_flen)
  );

  dfu_out_reg #(
    .FLEN_W (FLEN_W)
  ) u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .advance   (advance),
    .rsp       (rsp),
    .rsp_flen  (rsp_flen),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .out_flen  (out_flash_length)
  );

  assign out_handled       = out_rsp.handled;
  assign out_reply_length  = out_rsp.reply_length;
  assign out_status_code   = out_rsp.status_code;
  assign out_poll_timeout  = out_rsp.poll_timeout;
  assign out_state_code    = out_rsp.state_code;
  assign out_flash_command = out_rsp.flash_command;
  assign out_flash_address = out_rsp.flash_address;

endmodule

### sv/dfu_in_reg.sv
`timescale 1ns / 1ps

module dfu_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dfu_pkg::req_t in_req,
  input  logic          advance,
  output logic          req_valid,
  output dfu_pkg::req_t req
);
  import dfu_pkg::*;

  logic vld_r, vld_nxt;
  req_t req_r;

  assign in_ready  = !vld_r || advance;
  assign req_valid = vld_r;
  assign req       = req_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

endmodule

### sv/dfu_ctrl.sv
`timescale 1ns / 1ps

module dfu_ctrl #(
  parameter int BLOCK_BYTES = dfu_pkg::DFU_BLOCK_BYTES,
  parameter int FLEN_W      = $clog2(BLOCK_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              fire,
  input  dfu_pkg::req_t     req,
  output dfu_pkg::rsp_t     rsp,
  output logic [FLEN_W-1:0] rsp_flen
);
  import dfu_pkg::*;

  localparam logic [15:0]       BlockLen  = 16'(BLOCK_BYTES);
  localparam logic [31:0]       BlockMul  = 32'(BLOCK_BYTES);
  localparam logic [FLEN_W-1:0] BlockFlen = FLEN_W'(BLOCK_BYTES);

  logic        tsel_r;
  logic [31:0] app_base_r;
  logic [31:0] map_base_r;
  logic [31:0] marker_r;

  state_t            st_r, st_nxt;
  logic              status_r, status_nxt;
  logic [15:0]       pblk_r, pblk_nxt;
  logic [FLEN_W-1:0] plen_r, plen_nxt;
  logic              armed_r, armed_nxt;
  logic              mf_reset;
  logic [31:0]       base;

  assign base = tsel_r ? map_base_r : app_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsel_r     <= 1'b0;
      app_base_r <= '0;
      map_base_r <= '0;
      marker_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET_SEL: tsel_r     <= cfg_data[0];
        CFG_APP_BASE:   app_base_r <= cfg_data;
        CFG_MAP_BASE:   map_base_r <= cfg_data;
        CFG_MARKER:     marker_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      status_r <= STATUS_OK;
      pblk_r   <= '0;
      plen_r   <= '0;
      armed_r  <= 1'b0;
    end else if (fire) begin
      st_r     <= st_nxt;
      status_r <= status_nxt;
      pblk_r   <= pblk_nxt;
      plen_r   <= plen_nxt;
      armed_r  <= armed_nxt;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    status_nxt = status_r;
    pblk_nxt   = pblk_r;
    plen_nxt   = plen_r;
    armed_nxt  = armed_r;
    mf_reset   = 1'b0;
    rsp        = '0;
    rsp.handled = 1'b1;
    rsp.reply_length = LEN_NONE;
    rsp.flash_command = CMD_NONE;
    rsp_flen   = '0;

    if (op_t'(req.operation) == OP_STATUS_DONE) begin
      if (armed_r) begin
        armed_nxt = 1'b0;
        if (st_r == ST_DNBUSY) begin
          rsp.flash_command = CMD_PROGRAM;
          rsp.flash_address = base + 32'({16'd0, pblk_r} * BlockMul);
          rsp_flen          = plen_r;
          st_nxt            = ST_DNIDLE;
        end else if (st_r == ST_MANIFEST) begin
          rsp.flash_command = CMD_ERASE;
          rsp.flash_address = marker_r;
          mf_reset          = 1'b1;
        end
      end
    end else begin
      armed_nxt = 1'b0;
      if (req.request_type[6:5] != RTYPE_CLASS) begin
        rsp.handled = 1'b0;
      end else begin
        case (op_t'(req.operation))
          OP_DNLOAD: begin
            if (st_r inside {ST_IDLE, ST_DNIDLE}) begin
              pblk_nxt = req.block_number;
              plen_nxt = (req.transfer_length > BlockLen) ? BlockFlen
                                                          : FLEN_W'(req.transfer_length);
              st_nxt   = (req.transfer_length == 16'd0) ? ST_MFSYNC : ST_DNSYNC;
            end else begin
              status_nxt = STATUS_NOTDONE;
              st_nxt     = ST_ERROR;
            end
          end
          OP_GETSTATUS: begin
            if (st_r == ST_DNSYNC) begin
              st_nxt           = ST_DNBUSY;
              rsp.poll_timeout = POLL_MS;
              status_nxt       = STATUS_OK;
            end else if (st_r == ST_MFSYNC) begin
              st_nxt     = ST_MANIFEST;
              status_nxt = STATUS_OK;
            end else if (st_r != ST_ERROR) begin
              status_nxt = STATUS_OK;
            end
            rsp.reply_length = LEN_GETSTATUS;
            armed_nxt        = 1'b1;
          end
          OP_GETSTATE: begin
            rsp.reply_length = LEN_GETSTATE;
          end
          OP_CLRSTATUS: begin
            if (st_r == ST_ERROR) begin
              status_nxt = STATUS_OK;
              st_nxt     = ST_IDLE;
            end
          end
          OP_ABORT: begin
            status_nxt = STATUS_OK;
            st_nxt     = ST_IDLE;
          end
          default: begin
            rsp.handled = 1'b0;
          end
        endcase
      end
    end

    rsp.status_code = status_nxt;
    rsp.state_code  = st_nxt;

    if (mf_reset) begin
      st_nxt     = ST_IDLE;
      status_nxt = STATUS_OK;
      pblk_nxt   = '0;
      plen_nxt   = '0;
      armed_nxt  = 1'b0;
    end
  end

endmodule

### sv/dfu_out_reg.sv
`timescale 1ns / 1ps

module dfu_out_reg #(
  parameter int FLEN_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              advance,
  input  dfu_pkg::rsp_t     rsp,
  input  logic [FLEN_W-1:0] rsp_flen,
  output logic              out_valid,
  input  logic              out_ready,
  output dfu_pkg::rsp_t     out_rsp,
  output logic [FLEN_W-1:0] out_flen
);
  import dfu_pkg::*;

  logic              vld_r, vld_nxt;
  rsp_t              rsp_r;
  logic [FLEN_W-1:0] flen_r;
  logic              load;

  assign advance   = !vld_r || out_ready;
  assign load      = req_valid && advance;
  assign out_valid = vld_r;
  assign out_rsp   = rsp_r;
  assign out_flen  = flen_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r  <= rsp;
      flen_r <= rsp_flen;
    end
  end

endmodule

### sv/dfu_chk.sv
`timescale 1ns / 1ps

module dfu_chk #(
  parameter int FLEN_W = 11
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_handled,
  input logic [2:0]        out_reply_length,
  input logic [6:0]        out_poll_timeout,
  input logic [3:0]        out_state_code,
  input logic [1:0]        out_flash_command,
  input logic [31:0]       out_flash_address,
  input logic [FLEN_W-1:0] out_flash_length
);
  import dfu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flash_address)
      && $stable(out_flash_length) && $stable(out_state_code))
    else $error("reply changed while stalled");

  a_program_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flash_command == CMD_PROGRAM |-> out_state_code == ST_DNIDLE
      && out_handled && out_reply_length == LEN_NONE)
    else $error("program command outside dnload_idle transition");

  a_erase_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flash_command == CMD_ERASE |-> out_state_code == ST_MANIFEST
      && out_flash_length == '0)
    else $error("erase command outside manifest");

  a_stall_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_handled |-> out_reply_length == LEN_NONE
      && out_flash_command == CMD_NONE && out_poll_timeout == 7'd0)
    else $error("stalled request carries reply data");

  a_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_poll_timeout != 7'd0 |-> out_poll_timeout == POLL_MS
      && out_state_code == ST_DNBUSY && out_reply_length == LEN_GETSTATUS)
    else $error("poll timeout outside status query to dnbusy");

endmodule

bind dfu_request_state_machine_top dfu_chk #(.FLEN_W(FLEN_W)) u_dfu_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_handled       (out_handled),
  .out_reply_length  (out_reply_length),
  .out_poll_timeout  (out_poll_timeout),
  .out_state_code    (out_state_code),
  .out_flash_command (out_flash_command),
  .out_flash_address (out_flash_address),
  .out_flash_length  (out_flash_length)
);
